### rtl/gcke_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gcke_pkg
// Shared constants, types and reset values of the glove chord key encoder.
// ---------------------------------------------------------------------------
package gcke_pkg;

  // sizing
  localparam int KEY_SET_DEPTH = 32;
  localparam int SAMPLE_BITS   = 12;
  localparam int NUM_FINGERS   = 4;
  localparam int BOUNDS_W      = 4 * SAMPLE_BITS;
  localparam int CFG_IDX_W     = 2;
  localparam int CODE_W        = 7;
  localparam int NUM_CODES     = 81;
  localparam int KEY_LIMIT     = 72;
  localparam int COUNT_W       = $clog2(KEY_SET_DEPTH + 1);
  localparam int IDX_W         = (KEY_SET_DEPTH > 1) ? $clog2(KEY_SET_DEPTH) : 1;
  localparam int QUEUE_DEPTH   = 2;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // reset thresholds: floor, zone0 top, zone1 top, zone2 top
  localparam int FIRST_THR [4] = '{500, 900, 1150, 1700};
  localparam int OTHER_THR [4] = '{500, 1200, 1800, 2300};

  // one poll's work for the back end
  typedef struct packed {
    logic               flush;
    logic [COUNT_W-1:0] flush_count;
    logic [CODE_W-1:0]  code;
    logic               added;
    logic               drop;
    logic               collecting;
  } cmd_t;

  // key store write port
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [CODE_W-1:0]  data;
  } wr_t;

  // one result item
  typedef struct packed {
    logic               kind;
    logic [CODE_W-1:0]  chord_code;
    logic               key_valid;
    logic               newly_added;
    logic               set_full_drop;
    logic               collecting;
    logic               last_result;
  } res_t;

  // packed reset value of one finger's threshold register
  function automatic logic [BOUNDS_W-1:0] bounds_reset(input int finger);
    logic [BOUNDS_W-1:0] b;
    b = '0;
    for (int k = 0; k < 4; k++) begin
      b[k*SAMPLE_BITS +: SAMPLE_BITS] =
        SAMPLE_BITS'((finger == 0) ? FIRST_THR[k] : OTHER_THR[k]);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### rtl/gcke_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gcke_front
// Accepts polls, tracks button edges, classifies fingers into zones and
// maintains the collect set; hands one command per poll to the back end, none for a silent poll.
// ---------------------------------------------------------------------------
module gcke_front (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write_en,
  input  wire  [gcke_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [gcke_pkg::BOUNDS_W-1:0]         cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]      sample0,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]      sample1,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]      sample2,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]      sample3,
  input  wire                                   collect_button,
  input  wire                                   select_button,
  output logic                                  push_valid,
  input  wire                                   push_ready,
  output gcke_pkg::cmd_t                        push_data,
  output gcke_pkg::wr_t                         store_wr,
  input  wire                                   flush_done
);

  localparam int SB = gcke_pkg::SAMPLE_BITS;
  localparam int NF = gcke_pkg::NUM_FINGERS;
  localparam int CW = gcke_pkg::CODE_W;
  localparam int KW = gcke_pkg::COUNT_W;

  localparam logic [1:0] F_IDLE   = 2'd0;
  localparam logic [1:0] F_CLASS  = 2'd1;
  localparam logic [1:0] F_DECIDE = 2'd2;

  localparam logic [1:0] ZONE0 = 2'd0;
  localparam logic [1:0] ZONE1 = 2'd1;
  localparam logic [1:0] ZONE2 = 2'd2;

  logic [1:0]                      fstate;
  logic [gcke_pkg::BOUNDS_W-1:0]   bounds [NF];
  logic [SB-1:0]                   smp [NF];
  logic                            coll_lvl;
  logic                            sel_lvl;
  logic [1:0]                      zone [NF];
  logic [1:0]                      zone_next [NF];
  logic                            collect_mode;
  logic                            prev_collect;
  logic                            prev_select;
  logic [gcke_pkg::NUM_CODES-1:0]  seen;
  logic [KW-1:0]                   count;
  logic                            flush_pending;
  logic                            pend_flush;
  logic [KW-1:0]                   pend_count;
  logic [CW-1:0]                   code;
  logic [CW-1:0]                   code_next;
  logic                            collect_edge;
  logic                            select_edge;
  logic                            try_add;
  logic                            has_room;

  // zone of one sample; outside every zone keeps the old one
  function automatic logic [1:0] zone_of(input logic [SB-1:0] v,
                                         input logic [gcke_pkg::BOUNDS_W-1:0] b,
                                         input logic [1:0] keep);
    logic [SB-1:0] lo;
    logic [SB-1:0] t0;
    logic [SB-1:0] t1;
    logic [SB-1:0] t2;
    lo = b[0    +: SB];
    t0 = b[SB   +: SB];
    t1 = b[2*SB +: SB];
    t2 = b[3*SB +: SB];
    if (v >= lo && v <= t0) begin
      return ZONE0;
    end else if (v > t0 && v <= t1) begin
      return ZONE1;
    end else if (v > t1 && v <= t2) begin
      return ZONE2;
    end
    return keep;
  endfunction

  // classification and base-3 chord code
  always_comb begin
    for (int f = 0; f < NF; f++) begin
      zone_next[f] = zone_of(smp[f], bounds[f], zone[f]);
    end
    code_next = CW'(zone_next[0]) * CW'(27) + CW'(zone_next[1]) * CW'(9)
              + CW'(zone_next[2]) * CW'(3) + CW'(zone_next[3]);
  end

  assign collect_edge = coll_lvl & ~prev_collect;
  assign select_edge  = sel_lvl & ~prev_select;
  assign try_add      = select_edge & collect_mode & ~seen[code];
  assign has_room     = (count < KW'(gcke_pkg::KEY_SET_DEPTH));

  assign in_ready   = (fstate == F_IDLE) && !flush_pending;
  assign push_valid = (fstate == F_DECIDE);

  // command for the back end
  always_comb begin
    push_data.flush       = pend_flush;
    push_data.flush_count = pend_count;
    push_data.code        = code;
    push_data.added       = try_add & has_room;
    push_data.drop        = try_add & ~has_room;
    push_data.collecting  = collect_mode;
  end

  // append to key store
  always_comb begin
    store_wr.en   = push_valid && push_ready && try_add && has_room;
    store_wr.addr = count[gcke_pkg::IDX_W-1:0];
    store_wr.data = code;
  end

  // threshold registers
  always_ff @(posedge clk) begin
    for (int f = 0; f < NF; f++) begin
      if (rst) begin
        bounds[f] <= gcke_pkg::bounds_reset(f);
      end else if (cfg_write_en && cfg_index == gcke_pkg::CFG_IDX_W'(f)) begin
        bounds[f] <= cfg_data;
      end
    end
  end

  // poll capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp[0]   <= sample0;
      smp[1]   <= sample1;
      smp[2]   <= sample2;
      smp[3]   <= sample3;
      coll_lvl <= collect_button;
      sel_lvl  <= select_button;
    end
  end

  // per-poll sequencing and collect set state
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate        <= F_IDLE;
      for (int f = 0; f < NF; f++) begin
        zone[f] <= ZONE0;
      end
      collect_mode  <= 1'b0;
      prev_collect  <= 1'b0;
      prev_select   <= 1'b0;
      seen          <= '0;
      count         <= '0;
      flush_pending <= 1'b0;
      pend_flush    <= 1'b0;
      pend_count    <= '0;
      code          <= '0;
    end else begin
      if (flush_done) begin
        flush_pending <= 1'b0;
      end
      unique case (fstate)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            fstate <= F_CLASS;
          end
        end
        F_CLASS: begin
          prev_collect <= coll_lvl;
          pend_flush   <= 1'b0;
          if (collect_edge && collect_mode && count == '0) begin
            // second press with nothing stored: poll ends silently
            collect_mode <= 1'b0;
            fstate       <= F_IDLE;
          end else begin
            if (collect_edge && collect_mode) begin
              collect_mode <= 1'b0;
              pend_flush   <= 1'b1;
              pend_count   <= count;
              count        <= '0;
              seen         <= '0;
            end else if (collect_edge) begin
              collect_mode <= 1'b1;
            end
            for (int f = 0; f < NF; f++) begin
              zone[f] <= zone_next[f];
            end
            code   <= code_next;
            fstate <= F_DECIDE;
          end
        end
        F_DECIDE: begin
          if (push_ready) begin
            prev_select <= sel_lvl;
            if (try_add && has_room) begin
              count      <= count + KW'(1);
              seen[code] <= 1'b1;
            end
            if (pend_flush) begin
              flush_pending <= 1'b1;
            end
            fstate <= F_IDLE;
          end
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/gcke_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gcke_queue
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module gcke_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  output logic             push_ready,
  input  gcke_pkg::cmd_t   push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output gcke_pkg::cmd_t   pop_data
);

  localparam int QD = gcke_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNW = $clog2(QD + 1);

  gcke_pkg::cmd_t  slots [QD];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNW-1:0]  fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CNW'(QD));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/gcke_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gcke_back
// Executes commands: walks the key store for a flush, one code per cycle while the output register is free,
// then issues the chord report through the output register.
// ---------------------------------------------------------------------------
module gcke_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              cmd_valid,
  output logic             cmd_ready,
  input  gcke_pkg::cmd_t   cmd_in,
  input  gcke_pkg::wr_t    store_wr,
  output logic             flush_done,
  output logic             res_valid,
  input  wire              res_ready,
  output gcke_pkg::res_t   res
);

  localparam int IW = gcke_pkg::IDX_W;
  localparam int KW = gcke_pkg::COUNT_W;
  localparam int CW = gcke_pkg::CODE_W;

  localparam logic [1:0] B_IDLE   = 2'd0;
  localparam logic [1:0] B_EMIT   = 2'd1;
  localparam logic [1:0] B_REPORT = 2'd2;

  logic [1:0]       bstate;
  gcke_pkg::cmd_t   cmd;
  logic [CW-1:0]    mem [gcke_pkg::KEY_SET_DEPTH];
  logic [CW-1:0]    rd_data;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    rd_idx_next;
  logic             out_free;
  logic             last_code;

  assign cmd_ready = (bstate == B_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign last_code = (KW'(rd_idx) + KW'(1) == cmd.flush_count);

  // read address follows the walk so registered read data lines up with rd_idx
  always_comb begin
    rd_idx_next = rd_idx;
    unique case (bstate)
      B_IDLE:   rd_idx_next = '0;
      B_EMIT:   if (out_free) rd_idx_next = last_code ? '0 : rd_idx + IW'(1);
      B_REPORT: rd_idx_next = '0;
      default:  rd_idx_next = '0;
    endcase
  end

  // key store
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    rd_data <= mem[rd_idx_next];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= B_IDLE;
      rd_idx     <= '0;
      flush_done <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      flush_done <= 1'b0;
      rd_idx     <= rd_idx_next;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (bstate)
        B_IDLE: begin
          if (cmd_valid) begin
            cmd    <= cmd_in;
            bstate <= cmd_in.flush ? B_EMIT : B_REPORT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            res_valid         <= 1'b1;
            res.kind          <= gcke_pkg::KIND_FLUSH;
            res.chord_code    <= rd_data;
            res.key_valid     <= (rd_data < CW'(gcke_pkg::KEY_LIMIT));
            res.newly_added   <= 1'b0;
            res.set_full_drop <= 1'b0;
            res.collecting    <= 1'b0;
            res.last_result   <= 1'b0;
            if (last_code) begin
              flush_done <= 1'b1;
              bstate     <= B_REPORT;
            end
          end
        end
        B_REPORT: begin
          if (out_free) begin
            res_valid         <= 1'b1;
            res.kind          <= gcke_pkg::KIND_REPORT;
            res.chord_code    <= cmd.code;
            res.key_valid     <= (cmd.code < CW'(gcke_pkg::KEY_LIMIT));
            res.newly_added   <= cmd.added;
            res.set_full_drop <= cmd.drop;
            res.collecting    <= cmd.collecting;
            res.last_result   <= 1'b1;
            bstate            <= B_IDLE;
          end
        end
        default: begin
          bstate <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/glove_chord_key_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// glove_chord_key_encoder_top
// Chord key encoder for a four-finger sensor glove with a collect set.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one poll: four samples and two
// button levels. Output channel (out_valid/out_ready) gives result items;
// the last item of each poll has last_result set. A flush poll first gives
// the collected codes in insertion order, then its chord report.
// The front end handles each poll in the steps capture, classify and decide,
// and takes no new poll until it is done with the last one. A flush walks
// the key store at one code per cycle while the output register is free;
// new polls are held off until the walk is done.
// Threshold registers are written through cfg_write_en/cfg_index/cfg_data;
// the user must write them only while the block is idle, which it does not enforce.
// Reset restores default thresholds, clears zones, modes and the set.
// When the receiver stalls, the result waits in the output register, a
// two-entry command queue absorbs further polls, and then in_ready drops.
// ---------------------------------------------------------------------------
module glove_chord_key_encoder_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write_en,
  input  wire  [gcke_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [gcke_pkg::BOUNDS_W-1:0]     cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]  sample0,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]  sample1,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]  sample2,
  input  wire  [gcke_pkg::SAMPLE_BITS-1:0]  sample3,
  input  wire                               collect_button,
  input  wire                               select_button,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              kind,
  output logic [gcke_pkg::CODE_W-1:0]       chord_code,
  output logic                              key_valid,
  output logic                              newly_added,
  output logic                              set_full_drop,
  output logic                              collecting,
  output logic                              last_result
);

  logic             push_valid;
  logic             push_ready;
  gcke_pkg::cmd_t   push_data;
  logic             pop_valid;
  logic             pop_ready;
  gcke_pkg::cmd_t   pop_data;
  gcke_pkg::wr_t    store_wr;
  logic             flush_done;
  gcke_pkg::res_t   res;

  // poll intake and classification
  gcke_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample0        (sample0),
    .sample1        (sample1),
    .sample2        (sample2),
    .sample3        (sample3),
    .collect_button (collect_button),
    .select_button  (select_button),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data),
    .store_wr       (store_wr),
    .flush_done     (flush_done)
  );

  // command queue
  gcke_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // result generation
  gcke_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd_in     (pop_data),
    .store_wr   (store_wr),
    .flush_done (flush_done),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  // result fields
  assign kind          = res.kind;
  assign chord_code    = res.chord_code;
  assign key_valid     = res.key_valid;
  assign newly_added   = res.newly_added;
  assign set_full_drop = res.set_full_drop;
  assign collecting    = res.collecting;
  assign last_result   = res.last_result;

`ifndef ASSERT_OFF
  // front end handles one poll at a time
  a_one_poll: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("poll accepted while previous poll in front end");

  // flushed codes never carry report flags
  a_flush_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> !last_result && !collecting && !newly_added && !set_full_drop)
    else $error("flushed code carries report flags");

  // a code is only appended in collect mode
  a_add_collect: assert property (@(posedge clk) disable iff (rst)
    out_valid && newly_added |-> collecting && !set_full_drop)
    else $error("append reported outside collect mode");
`endif

endmodule
`default_nettype wire
